>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, quiet while reset is asserted.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/tked_pkg.sv
package tked_pkg;

  // Counter widths for the CSI prefix and parameter bookkeeping
  localparam int unsigned PREFIX_CNT_W = 6;
  localparam int unsigned PARAM_CNT_W  = 4;

  // Key event codes
  typedef enum logic [3:0] {
    K_PLAIN = 4'd0,
    K_ESC   = 4'd1,
    K_UP    = 4'd2,
    K_DOWN  = 4'd3,
    K_LEFT  = 4'd4,
    K_RIGHT = 4'd5,
    K_HOME  = 4'd6,
    K_END   = 4'd7,
    K_PGUP  = 4'd8,
    K_PGDN  = 4'd9,
    K_DEL   = 4'd10
  } key_kind_e;

  // Decoder phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_SS3  = 2'd2,
    PH_CSI  = 2'd3
  } phase_e;

  // Which tilde key the parameters asked for
  typedef enum logic [1:0] {
    TM_NONE = 2'd0,
    TM_PGUP = 2'd1,
    TM_PGDN = 2'd2,
    TM_DEL  = 2'd3
  } tilde_e;

  // Byte values
  localparam logic [7:0] CH_ESC      = 8'd27;
  localparam logic [7:0] CH_O        = 8'h4F;
  localparam logic [7:0] CH_LBRACK   = 8'h5B;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_LOW_F    = 8'h66;
  localparam logic [7:0] CH_TILDE    = 8'h7E;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_9        = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_COLON    = 8'h3A;
  localparam logic [7:0] FINAL_LO    = 8'h40;
  localparam logic [7:0] FINAL_HI    = 8'h7E;
  localparam logic [7:0] NAV_HOME    = 8'hE0;
  localparam logic [7:0] NAV_END     = 8'hE1;
  localparam logic [7:0] NAV_UP      = 8'hE2;
  localparam logic [7:0] NAV_DOWN    = 8'hE3;
  localparam logic [7:0] NAV_LEFT    = 8'hE4;
  localparam logic [7:0] NAV_RIGHT   = 8'hE5;
  localparam logic [7:0] NAV_PGUP    = 8'hE6;
  localparam logic [7:0] NAV_PGDN    = 8'hE7;
  localparam logic [7:0] NAV_DEL     = 8'hE9;
  localparam logic [7:0] PARAM_SAT   = 8'd255;
  localparam logic [7:0] PV_ONE      = 8'd1;
  localparam logic [7:0] PV_PGUP     = 8'd5;
  localparam logic [7:0] PV_PGDN     = 8'd6;
  localparam logic [7:0] PV_DEL      = 8'd3;

  // One key event
  typedef struct packed {
    key_kind_e  kind;
    logic [7:0] key_byte;
  } key_res_t;

  // Events caused by one input byte, in order
  typedef struct packed {
    logic [1:0] num;
    key_res_t   res0;
    key_res_t   res1;
  } dec_out_t;

  // Parameter summary kept while inside CSI
  typedef struct packed {
    logic [PARAM_CNT_W-1:0] cnt;
    logic                   first_one;
    tilde_e                 tilde;
  } csi_par_t;

  // Decode of a byte seen with no sequence open
  typedef struct packed {
    logic     emit;
    logic     opens_esc;
    key_res_t res;
  } fresh_t;

endpackage

>>> hw/rtl/tked_core.sv
module tked_core #(
  parameter int unsigned PREFIX_MAX = 62,
  parameter int unsigned PARAM_MAX  = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic              eoi_i,
  output tked_pkg::dec_out_t dec_o
);
  import tked_pkg::*;

  `include "assert_macros.svh"

  phase_e                  phase_q, phase_d;
  logic [PREFIX_CNT_W-1:0] prefix_cnt_q, prefix_cnt_d;
  csi_par_t                par_q, par_d;
  logic [7:0]              pval_q, pval_d;
  logic                    digit_seen_q, digit_seen_d;
  logic                    prefix_bad_q, prefix_bad_d;

  logic     e0_vld, e1_vld;
  key_res_t e0, e1;
  fresh_t   fr;
  csi_par_t par_fin;
  logic     is_final, is_digit;
  logic [11:0] pval_mul;

  localparam csi_par_t ParClear = '{cnt: '0, first_one: 1'b0, tilde: TM_NONE};

  // Single keyboard navigation codes
  function automatic key_kind_e nav_kind(logic [7:0] c);
    key_kind_e k;
    unique case (c)
      NAV_HOME:  k = K_HOME;
      NAV_END:   k = K_END;
      NAV_UP:    k = K_UP;
      NAV_DOWN:  k = K_DOWN;
      NAV_LEFT:  k = K_LEFT;
      NAV_RIGHT: k = K_RIGHT;
      NAV_PGUP:  k = K_PGUP;
      NAV_PGDN:  k = K_PGDN;
      NAV_DEL:   k = K_DEL;
      default:   k = K_PLAIN;
    endcase
    return k;
  endfunction

  // Record one finished parameter
  function automatic csi_par_t push_param(csi_par_t p, logic [7:0] v);
    csi_par_t r;
    r = p;
    if (p.cnt < PARAM_CNT_W'(PARAM_MAX)) begin
      if (p.cnt == '0) r.first_one = (v == PV_ONE);
      if (p.tilde == TM_NONE) begin
        priority if (v == PV_PGUP) r.tilde = TM_PGUP;
        else if (v == PV_PGDN) r.tilde = TM_PGDN;
        else if (v == PV_DEL) r.tilde = TM_DEL;
        else r.tilde = TM_NONE;
      end
      r.cnt = p.cnt + 1'b1;
    end
    return r;
  endfunction

  // Byte decoded with no sequence open
  always_comb begin
    key_kind_e nk;
    nk = nav_kind(byte_i);
    fr.opens_esc    = 1'b0;
    fr.emit         = 1'b1;
    fr.res.kind     = nk;
    fr.res.key_byte = 8'd0;
    if (nk == K_PLAIN) begin
      if (byte_i == CH_ESC) begin
        fr.emit      = 1'b0;
        fr.opens_esc = 1'b1;
      end else begin
        fr.res.key_byte = byte_i;
      end
    end
  end

  assign is_final = (byte_i >= FINAL_LO) && (byte_i <= FINAL_HI);
  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign par_fin  = digit_seen_q ? push_param(par_q, pval_q) : par_q;
  assign pval_mul = ({4'd0, pval_q} << 3) + ({4'd0, pval_q} << 1)
                  + {8'd0, byte_i[3:0]};

  // Next state and the events of this byte
  always_comb begin
    phase_d      = phase_q;
    prefix_cnt_d = prefix_cnt_q;
    par_d        = par_q;
    pval_d       = pval_q;
    digit_seen_d = digit_seen_q;
    prefix_bad_d = prefix_bad_q;
    e0_vld       = 1'b0;
    e0           = '{kind: K_ESC, key_byte: 8'd0};
    e1_vld       = 1'b0;
    e1           = fr.res;

    if (eoi_i) begin
      e0_vld       = (phase_q != PH_IDLE);
      phase_d      = PH_IDLE;
      prefix_cnt_d = '0;
      par_d        = ParClear;
      pval_d       = 8'd0;
      digit_seen_d = 1'b0;
      prefix_bad_d = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          e1_vld  = fr.emit;
          phase_d = fr.opens_esc ? PH_ESC : PH_IDLE;
        end
        PH_ESC: begin
          if (byte_i == CH_O) begin
            phase_d = PH_SS3;
          end else if (byte_i == CH_LBRACK) begin
            phase_d      = PH_CSI;
            prefix_cnt_d = '0;
            par_d        = ParClear;
            pval_d       = 8'd0;
            digit_seen_d = 1'b0;
            prefix_bad_d = 1'b0;
          end else begin
            e0_vld  = 1'b1;
            e1_vld  = fr.emit;
            phase_d = fr.opens_esc ? PH_ESC : PH_IDLE;
          end
        end
        PH_SS3: begin
          e0_vld  = 1'b1;
          phase_d = PH_IDLE;
          unique case (byte_i)
            CH_A:    e0.kind = K_UP;
            CH_B:    e0.kind = K_DOWN;
            CH_C:    e0.kind = K_RIGHT;
            CH_D:    e0.kind = K_LEFT;
            CH_H:    e0.kind = K_HOME;
            CH_F:    e0.kind = K_END;
            default: begin
              e1_vld  = fr.emit;
              phase_d = fr.opens_esc ? PH_ESC : PH_IDLE;
            end
          endcase
        end
        PH_CSI: begin
          if (is_final || prefix_cnt_q >= PREFIX_CNT_W'(PREFIX_MAX)) begin
            // Sequence ends: report and clear
            e0_vld       = 1'b1;
            phase_d      = PH_IDLE;
            prefix_cnt_d = '0;
            par_d        = ParClear;
            pval_d       = 8'd0;
            digit_seen_d = 1'b0;
            prefix_bad_d = 1'b0;
            if (is_final) begin
              priority if (byte_i == CH_A) e0.kind = K_UP;
              else if (byte_i == CH_B) e0.kind = K_DOWN;
              else if (byte_i == CH_C) e0.kind = K_RIGHT;
              else if (byte_i == CH_D) e0.kind = K_LEFT;
              else if (prefix_bad_q) e0.kind = K_ESC;
              else if (byte_i == CH_H || byte_i == CH_LOW_F) begin
                if (par_fin.cnt == '0 ||
                    (par_fin.cnt == PARAM_CNT_W'(1) && par_fin.first_one)) begin
                  e0.kind = K_HOME;
                end else begin
                  e0.kind = K_ESC;
                end
              end
              else if (byte_i == CH_F) e0.kind = K_END;
              else if (byte_i == CH_TILDE) begin
                unique case (par_fin.tilde)
                  TM_PGUP: e0.kind = K_PGUP;
                  TM_PGDN: e0.kind = K_PGDN;
                  TM_DEL:  e0.kind = K_DEL;
                  default: e0.kind = K_ESC;
                endcase
              end
              else e0.kind = K_ESC;
            end
          end else begin
            // Prefix byte
            prefix_cnt_d = prefix_cnt_q + 1'b1;
            if (is_digit) begin
              pval_d       = (pval_mul > 12'(PARAM_SAT)) ? PARAM_SAT : pval_mul[7:0];
              digit_seen_d = 1'b1;
            end else if (byte_i == CH_SEMI || byte_i == CH_COLON) begin
              par_d        = push_param(par_q, digit_seen_q ? pval_q : 8'd0);
              pval_d       = 8'd0;
              digit_seen_d = 1'b0;
            end else begin
              prefix_bad_d = 1'b1;
            end
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // Pack the events in order
  always_comb begin
    if (e0_vld) begin
      dec_o.res0 = e0;
      dec_o.res1 = e1;
      dec_o.num  = e1_vld ? 2'd2 : 2'd1;
    end else begin
      dec_o.res0 = e1;
      dec_o.res1 = e1;
      dec_o.num  = e1_vld ? 2'd1 : 2'd0;
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      prefix_cnt_q <= '0;
      par_q        <= ParClear;
      pval_q       <= 8'd0;
      digit_seen_q <= 1'b0;
      prefix_bad_q <= 1'b0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      prefix_cnt_q <= prefix_cnt_d;
      par_q        <= par_d;
      pval_q       <= pval_d;
      digit_seen_q <= digit_seen_d;
      prefix_bad_q <= prefix_bad_d;
    end
  end

  `ASSERT_ALWAYS(a_csi_state_clear,
    phase_q != PH_CSI |-> (prefix_cnt_q == '0 && par_q.cnt == '0 && !digit_seen_q),
    "CSI bookkeeping not clear outside a CSI sequence")
  `ASSERT_RST(a_prefix_bound, prefix_cnt_q <= PREFIX_CNT_W'(PREFIX_MAX),
    "CSI prefix count beyond its limit")
  `ASSERT_RST(a_param_bound, par_q.cnt <= PARAM_CNT_W'(PARAM_MAX),
    "CSI parameter count beyond its limit")

endmodule

>>> hw/rtl/terminal_key_escape_decoder_top.sv
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] byte, tuser[0] end of input
// m_axis    out        tdata[3:0] key kind, tdata[11:4] key byte, tlast last event
//
// One request enters per cycle while s_axis_tready is high. It moves from the input
// register into the result register once the result register is free, and its first
// event is then offered from the result register.
// A byte that yields two events holds the result register until both are taken,
// which holds the input side off while both events wait.
// Reset returns the decoder to idle with no sequence open and both stages empty.
// A stalled output stalls the input side only when the result register cannot
// take the next request's events.
module terminal_key_escape_decoder_top #(
  parameter int unsigned PREFIX_MAX = 62,
  parameter int unsigned PARAM_MAX  = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [3:0] key_kind, [11:4] key_byte, [15:12] zero
  output logic        m_axis_tlast
);
  import tked_pkg::*;

  `include "assert_macros.svh"

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eoi_q;
  logic       advance, res_free, pop;
  logic [1:0] res_cnt_q;
  key_res_t   res0_q, res1_q;
  dec_out_t   dec;

  tked_core #(
    .PREFIX_MAX(PREFIX_MAX),
    .PARAM_MAX (PARAM_MAX)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .byte_i(in_byte_q),
    .eoi_i (in_eoi_q),
    .dec_o (dec)
  );

  // Handshake control
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign res_free      = (res_cnt_q == 2'd0) || (res_cnt_q == 2'd1 && m_axis_tready);
  assign advance       = in_vld_q && res_free;
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_eoi_q  <= s_axis_tuser[0];
    end
  end

  // Result register, two event slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_cnt_q <= 2'd0;
    end else if (advance) begin
      res_cnt_q <= dec.num;
    end else if (pop) begin
      res_cnt_q <= res_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res0_q <= dec.res0;
      res1_q <= dec.res1;
    end else if (pop && res_cnt_q == 2'd2) begin
      res0_q <= res1_q;
    end
  end

  assign m_axis_tvalid = (res_cnt_q != 2'd0);
  assign m_axis_tlast  = (res_cnt_q == 2'd1);
  assign m_axis_tdata  = {4'd0, res0_q.key_byte, res0_q.kind};

  `ASSERT_RST(a_res_cnt_range, res_cnt_q != 2'd3, "result slot count out of range")
  `ASSERT_RST(a_pair_shift, (res_cnt_q == 2'd2 && m_axis_tready) |=> res_cnt_q == 2'd1,
    "second event lost or repeated after a pop")
  `ASSERT_RST(a_byte_only_plain,
    (m_axis_tvalid && res0_q.kind != K_PLAIN) |-> res0_q.key_byte == 8'd0,
    "key byte set on a non-plain event")

endmodule

>>> tb/tb_terminal_key_escape_decoder_top.sv
`timescale 1ns / 1ps

module tb_terminal_key_escape_decoder_top;
  import tked_pkg::*;

  localparam int unsigned PREFIX_LIMIT = 62;
  localparam int unsigned PARAM_LIMIT  = 8;
  localparam int unsigned MAX_REPORTS  = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic [0:0]  s_axis_tuser = 1'b0;    // [0] end_of_input
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [3:0] key_kind, [11:4] key_byte, [15:12] zero
  logic        m_axis_tlast;

  terminal_key_escape_decoder_top #(
    .PREFIX_MAX(PREFIX_LIMIT),
    .PARAM_MAX (PARAM_LIMIT)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expected key events, oldest first
  typedef struct packed {
    key_kind_e  kind;
    logic [7:0] key_byte;
    logic       last;
  } key_event_t;

  key_event_t pending_keys[$];
  key_event_t want_key;

  int errors = 0;
  int requests_sent = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Decoder state as the testbench tracks it
  phase_e     dec_phase;
  logic [5:0] pfx_cnt;
  logic [3:0] par_cnt;
  logic [7:0] par_val;
  logic       digit_seen;
  logic       pfx_bad;
  logic       first_one;
  tilde_e     tilde_key;

  // Events produced by the request being decoded
  key_kind_e  step_kind [2];
  logic [7:0] step_byte [2];
  int         step_n;

  function void emit_key(key_kind_e k, logic [7:0] b);
    step_kind[step_n] = k;
    step_byte[step_n] = b;
    step_n++;
  endfunction

  function void clear_csi_state();
    pfx_cnt    = '0;
    par_cnt    = '0;
    par_val    = '0;
    digit_seen = 1'b0;
    pfx_bad    = 1'b0;
    first_one  = 1'b0;
    tilde_key  = TM_NONE;
  endfunction

  // A finished CSI parameter; only the first PARAM_LIMIT count
  function void record_param(logic [7:0] v);
    if (par_cnt >= PARAM_LIMIT) return;
    if (par_cnt == 0) first_one = (v == PV_ONE);
    if (tilde_key == TM_NONE) begin
      if (v == PV_PGUP) tilde_key = TM_PGUP;
      else if (v == PV_PGDN) tilde_key = TM_PGDN;
      else if (v == PV_DEL) tilde_key = TM_DEL;
    end
    par_cnt++;
  endfunction

  // Byte seen with no sequence open
  function void decode_fresh(logic [7:0] c);
    case (c)
      NAV_HOME:  emit_key(K_HOME, 8'h00);
      NAV_END:   emit_key(K_END, 8'h00);
      NAV_UP:    emit_key(K_UP, 8'h00);
      NAV_DOWN:  emit_key(K_DOWN, 8'h00);
      NAV_LEFT:  emit_key(K_LEFT, 8'h00);
      NAV_RIGHT: emit_key(K_RIGHT, 8'h00);
      NAV_PGUP:  emit_key(K_PGUP, 8'h00);
      NAV_PGDN:  emit_key(K_PGDN, 8'h00);
      NAV_DEL:   emit_key(K_DEL, 8'h00);
      CH_ESC:    dec_phase = PH_ESC;
      default:   emit_key(K_PLAIN, c);
    endcase
  endfunction

  // Byte seen inside a CSI sequence
  function void decode_csi(logic [7:0] c);
    int        acc;
    key_kind_e k;
    if (c >= FINAL_LO && c <= FINAL_HI) begin
      if (c == CH_A) k = K_UP;
      else if (c == CH_B) k = K_DOWN;
      else if (c == CH_C) k = K_RIGHT;
      else if (c == CH_D) k = K_LEFT;
      else if (pfx_bad) k = K_ESC;
      else begin
        if (digit_seen) record_param(par_val);
        if (c == CH_H || c == CH_LOW_F)
          k = (par_cnt == 0 || (par_cnt == 1 && first_one)) ? K_HOME : K_ESC;
        else if (c == CH_F) k = K_END;
        else if (c == CH_TILDE && tilde_key == TM_PGUP) k = K_PGUP;
        else if (c == CH_TILDE && tilde_key == TM_PGDN) k = K_PGDN;
        else if (c == CH_TILDE && tilde_key == TM_DEL) k = K_DEL;
        else k = K_ESC;
      end
      emit_key(k, 8'h00);
      dec_phase = PH_IDLE;
      clear_csi_state();
    end else if (pfx_cnt >= PREFIX_LIMIT) begin
      // prefix full: give up on the sequence
      emit_key(K_ESC, 8'h00);
      dec_phase = PH_IDLE;
      clear_csi_state();
    end else begin
      pfx_cnt++;
      if (c >= CH_0 && c <= CH_9) begin
        acc = int'(par_val) * 10 + (int'(c) - int'(CH_0));
        par_val = (acc > 255) ? PARAM_SAT : acc[7:0];
        digit_seen = 1'b1;
      end else if (c == CH_SEMI || c == CH_COLON) begin
        record_param(digit_seen ? par_val : 8'h00);
        par_val = '0;
        digit_seen = 1'b0;
      end else begin
        pfx_bad = 1'b1;
      end
    end
  endfunction

  // Work out the events of one accepted request and queue them
  function void predict_request(logic [7:0] c, logic eoi);
    int i;
    step_n = 0;
    if (eoi) begin
      if (dec_phase != PH_IDLE) emit_key(K_ESC, 8'h00);
      dec_phase = PH_IDLE;
      clear_csi_state();
    end else begin
      case (dec_phase)
        PH_IDLE: decode_fresh(c);
        PH_ESC: begin
          if (c == CH_O) begin
            dec_phase = PH_SS3;
          end else if (c == CH_LBRACK) begin
            dec_phase = PH_CSI;
            clear_csi_state();
          end else begin
            emit_key(K_ESC, 8'h00);
            dec_phase = PH_IDLE;
            decode_fresh(c);
          end
        end
        PH_SS3: begin
          dec_phase = PH_IDLE;
          case (c)
            CH_A: emit_key(K_UP, 8'h00);
            CH_B: emit_key(K_DOWN, 8'h00);
            CH_C: emit_key(K_RIGHT, 8'h00);
            CH_D: emit_key(K_LEFT, 8'h00);
            CH_H: emit_key(K_HOME, 8'h00);
            CH_F: emit_key(K_END, 8'h00);
            default: begin
              emit_key(K_ESC, 8'h00);
              decode_fresh(c);
            end
          endcase
        end
        default: decode_csi(c);
      endcase
    end
    for (i = 0; i < step_n; i++)
      pending_keys.push_back({step_kind[i], step_byte[i], (i == step_n - 1)});
  endfunction

  // Output side: random stall
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Output side: compare each event with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_keys.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected event: expected none, got kind %0d byte %0h last %0b",
                   $time, m_axis_tdata[3:0], m_axis_tdata[11:4], m_axis_tlast);
        errors++;
      end else begin
        want_key = pending_keys.pop_front();
        if (m_axis_tdata[3:0] !== want_key.kind) begin
          if (errors < MAX_REPORTS)
            $display("%0t: key_kind mismatch: expected %0d, got %0d",
                     $time, want_key.kind, m_axis_tdata[3:0]);
          errors++;
        end
        if (m_axis_tdata[11:4] !== want_key.key_byte) begin
          if (errors < MAX_REPORTS)
            $display("%0t: key_byte mismatch: expected %0h, got %0h",
                     $time, want_key.key_byte, m_axis_tdata[11:4]);
          errors++;
        end
        if (m_axis_tlast !== want_key.last) begin
          if (errors < MAX_REPORTS)
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, want_key.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  // One request on the input side, with random idle cycles ahead of it
  task automatic send_request(logic [7:0] b, logic eoi);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eoi;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_request(b, eoi);
    requests_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  // Hold the input side off until every expected event has come out
  task automatic wait_for_drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_keys.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Plain bytes, navigation codes, and end of input while idle
  task automatic test_single_bytes();
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hE8, 1'b0);
    send_request(NAV_HOME, 1'b0);
    send_request(NAV_DEL, 1'b0);
    send_request(8'hFF, 1'b1);
  endtask

  // SS3 keys, other bytes after ESC and after ESC O, ESC twice
  task automatic test_escape_sequences();
    send_request(CH_ESC, 1'b0);
    send_text("OA");
    send_request(CH_ESC, 1'b0);
    send_text("Ox");
    send_request(CH_ESC, 1'b0);
    send_request(CH_ESC, 1'b0);
    send_text("[6~");
  endtask

  // Home with a wrong parameter, arrow after a bad prefix byte
  task automatic test_csi_prefix();
    send_request(CH_ESC, 1'b0);
    send_text("[2f");
    send_request(CH_ESC, 1'b0);
    send_text("[?A");
  endtask

  // End of input flushes an open sequence
  task automatic test_end_of_input();
    send_request(CH_ESC, 1'b0);
    send_request(8'h5B, 1'b1);
  endtask

  // One random sequence: mostly well-formed escapes with random content
  task automatic send_random_sequence();
    int    pick;
    int    nparams;
    int    v;
    string digits;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      send_request(CH_ESC, 1'b0);
      send_request(CH_LBRACK, 1'b0);
      if ($urandom_range(0, 19) == 0) begin
        // long prefix, may overflow; digit runs saturate
        repeat ($urandom_range(55, 70)) begin
          if ($urandom_range(0, 7) == 0) send_request(CH_SEMI, 1'b0);
          else send_request(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
        end
      end else begin
        nparams = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(0, 11);
        for (int p = 0; p < nparams; p++) begin
          if (p > 0) send_request($urandom_range(0, 1) ? CH_SEMI : CH_COLON, 1'b0);
          if ($urandom_range(0, 5) != 0) begin
            case ($urandom_range(0, 5))
              0: v = 1;
              1: v = 3;
              2: v = 5;
              3: v = 6;
              4: v = $urandom_range(0, 400);
              default: v = $urandom_range(0, 9);
            endcase
            digits = $sformatf("%0d", v);
            if ($urandom_range(0, 7) == 0) send_request(CH_0, 1'b0);
            send_text(digits);
          end
          if ($urandom_range(0, 11) == 0) begin
            // noise that cannot be a final byte
            v = $urandom_range(0, 255);
            if (v >= FINAL_LO && v <= FINAL_HI) v = v ^ 8'h80;
            send_request(8'(v), 1'b0);
          end
        end
      end
      if ($urandom_range(0, 29) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0: send_request(CH_A, 1'b0);
          1: send_request(CH_B, 1'b0);
          2: send_request(CH_C, 1'b0);
          3: send_request(CH_D, 1'b0);
          4: send_request(CH_H, 1'b0);
          5: send_request(CH_LOW_F, 1'b0);
          6: send_request(CH_F, 1'b0);
          7, 8: send_request(CH_TILDE, 1'b0);
          default: send_request(8'($urandom_range(FINAL_LO, FINAL_HI)), 1'b0);
        endcase
      end
    end else if (pick < 50) begin
      send_request(CH_ESC, 1'b0);
      send_request(CH_O, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        send_request(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        case ($urandom_range(0, 5))
          0: send_request(CH_A, 1'b0);
          1: send_request(CH_B, 1'b0);
          2: send_request(CH_C, 1'b0);
          3: send_request(CH_D, 1'b0);
          4: send_request(CH_H, 1'b0);
          default: send_request(CH_F, 1'b0);
        endcase
      end
    end else if (pick < 60) begin
      send_request(CH_ESC, 1'b0);
      send_request($urandom_range(0, 3) == 0 ? CH_ESC : 8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 72) begin
      send_request(8'(NAV_HOME + $urandom_range(0, 9)), 1'b0);
    end else if (pick < 95) begin
      send_request(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_request(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic run_traffic_phase(int n_requests, int idle_pct, int stall_pct);
    int target;
    target = requests_sent + n_requests;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    while (requests_sent < target) send_random_sequence();
    wait_for_drain();
  endtask

  // Random traffic under the four idle and stall settings
  task automatic test_random_traffic();
    run_traffic_phase(300, 0, 0);
    run_traffic_phase(300, 77, 0);
    run_traffic_phase(300, 0, 77);
    run_traffic_phase(300, 22, 22);
  endtask

  initial begin
    dec_phase = PH_IDLE;
    clear_csi_state();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_escape_sequences();
    test_csi_prefix();
    test_end_of_input();
    wait_for_drain();
    test_random_traffic();

    if (pending_keys.size() != 0) begin
      $display("%0t: %0d expected events never arrived, next kind %0d",
               $time, pending_keys.size(), pending_keys[0].kind);
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tked_pkg.sv
hw/rtl/tked_core.sv
hw/rtl/terminal_key_escape_decoder_top.sv
tb/tb_terminal_key_escape_decoder_top.sv
